@@ design/irigb_pkg.sv @@
// Shared types, symbol codes, register indexes and BCD weight table
// for the IRIG-B time code decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irigb_pkg;

	localparam int TICK_COUNT_WIDTH_DEF = 10;
	localparam int THR_W = 8;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_ZERO_MIN = 2'd0;
	localparam logic [1:0] REG_ZERO_MAX = 2'd1;
	localparam logic [1:0] REG_MARK_MIN = 2'd2;
	localparam logic [1:0] REG_MARK_MAX = 2'd3;

	// Position of the marker that triggers the second advance, and the last marker slot
	localparam logic [3:0] MARK_PUBLISH = 4'd7;
	localparam logic [3:0] MARK_LAST    = 4'd8;

	typedef enum logic [1:0] {
		SYM_ZERO = 2'd0,
		SYM_ONE  = 2'd1,
		SYM_MARK = 2'd2,
		SYM_NONE = 2'd3
	} sym_t;

	typedef struct packed {
		logic [THR_W-1:0] zero_min;
		logic [THR_W-1:0] zero_max;
		logic [THR_W-1:0] mark_min;
		logic [THR_W-1:0] mark_max;
	} thr_t;

	// One classified pulse, valid on the beat in which the line falls
	typedef struct packed {
		logic valid;
		sym_t sym;
	} sym_evt_t;

	// Packed so that seconds land in the lowest bits
	typedef struct packed {
		logic [7:0] year;
		logic [3:0] tenths;
		logic [8:0] day_of_year;
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
	} time_t;

	// BCD weight of data bit i within a group; bits past the ninth add nothing
	function automatic logic [8:0] bcd_weight(input logic [4:0] i);
		logic [8:0] w;
		unique case (i)
			5'd0: w = 9'd1;
			5'd1: w = 9'd2;
			5'd2: w = 9'd4;
			5'd3: w = 9'd8;
			5'd5: w = 9'd10;
			5'd6: w = 9'd20;
			5'd7: w = 9'd40;
			5'd8: w = 9'd80;
			default: w = 9'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ design/irigb_pulse.sv @@
// High pulse length counter and symbol classifier.
// Depends on irigb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irigb_pulse
	import irigb_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     level,
	input  wire thr_t     thr,
	output sym_evt_t      evt
);

	localparam int CW = (TICK_COUNT_WIDTH > THR_W) ? TICK_COUNT_WIDTH : THR_W;

	logic                        pulse_active_q;
	logic [TICK_COUNT_WIDTH-1:0] pulse_ticks_q;
	logic [CW-1:0]               len;

	assign len = CW'(pulse_ticks_q);

	always_comb begin
		evt.valid = !level && pulse_active_q;
		// marker test first, anything not a marker or a zero is a one
		if (len >= CW'(thr.mark_min) && len <= CW'(thr.mark_max)) begin
			evt.sym = SYM_MARK;
		end else if (len >= CW'(thr.zero_min) && len <= CW'(thr.zero_max)) begin
			evt.sym = SYM_ZERO;
		end else begin
			evt.sym = SYM_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_active_q <= 1'b0;
			pulse_ticks_q  <= '0;
		end else if (adv) begin
			if (level) begin
				if (!pulse_active_q) begin
					pulse_active_q <= 1'b1;
					pulse_ticks_q  <= TICK_COUNT_WIDTH'(1);
				end else if (pulse_ticks_q != {TICK_COUNT_WIDTH{1'b1}}) begin
					pulse_ticks_q <= pulse_ticks_q + TICK_COUNT_WIDTH'(1);
				end
			end else if (pulse_active_q) begin
				pulse_active_q <= 1'b0;
				pulse_ticks_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/irigb_frame.sv @@
// Frame tracker: marker counting, BCD accumulation, second advance and
// the published time with its event flags. Depends on irigb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irigb_frame
	import irigb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire sym_evt_t evt,
	output logic          frame_start,
	output logic          time_update,
	output time_t         pub
);

	sym_t        last_symbol_q;
	logic        in_frame_q;
	logic [3:0]  marker_index_q;
	logic [4:0]  group_bit_index_q;
	logic [8:0]  group_sum_q;
	time_t       work_q;
	time_t       pub_q;
	logic        frame_start_q;
	logic        time_update_q;

	sym_t        last_symbol_d;
	logic        in_frame_d;
	logic [3:0]  marker_index_d;
	logic [4:0]  group_bit_index_d;
	logic [8:0]  group_sum_d;
	time_t       work_d;
	time_t       pub_d;
	logic        frame_start_d;
	logic        time_update_d;

	always_comb begin
		logic [3:0] mi;
		logic [3:0] bump;
		last_symbol_d     = last_symbol_q;
		in_frame_d        = in_frame_q;
		marker_index_d    = marker_index_q;
		group_bit_index_d = group_bit_index_q;
		group_sum_d       = group_sum_q;
		work_d            = work_q;
		pub_d             = pub_q;
		frame_start_d     = 1'b0;
		time_update_d     = 1'b0;
		mi                = (marker_index_q >= MARK_LAST) ? 4'd0 : marker_index_q + 4'd1;
		unique case (group_bit_index_q)
			5'd5: bump = 4'd1;
			5'd6: bump = 4'd2;
			5'd7: bump = 4'd4;
			5'd8: bump = 4'd8;
			default: bump = 4'd0;
		endcase

		if (evt.valid) begin
			last_symbol_d = evt.sym;
			if (evt.sym == SYM_MARK && last_symbol_q == SYM_MARK) begin
				// double marker: frame reference
				frame_start_d     = 1'b1;
				in_frame_d        = 1'b1;
				marker_index_d    = 4'd0;
				group_sum_d       = 9'd0;
				group_bit_index_d = 5'd0;
			end else if (in_frame_q) begin
				if (evt.sym == SYM_MARK) begin
					marker_index_d    = mi;
					group_sum_d       = 9'd0;
					group_bit_index_d = 5'd0;
					unique case (mi)
						4'd1: work_d.seconds = group_sum_q[7:0];
						4'd2: work_d.minutes = group_sum_q[7:0];
						4'd3: work_d.hours   = group_sum_q[7:0];
						4'd4: begin
							work_d.day_of_year = group_sum_q;
							work_d.tenths      = 4'd0;
						end
						4'd5: work_d.day_of_year = work_q.day_of_year + group_sum_q;
						4'd6: work_d.year = group_sum_q[7:0];
						MARK_PUBLISH: begin
							// each field wraps on an exact match, tested in order
							work_d.seconds = work_q.seconds + 8'd1;
							if (work_d.seconds == 8'd60) begin
								work_d.seconds = 8'd0;
								work_d.minutes = work_d.minutes + 8'd1;
							end
							if (work_d.minutes == 8'd60) begin
								work_d.minutes = 8'd0;
								work_d.hours   = work_d.hours + 8'd1;
							end
							if (work_d.hours == 8'd24) begin
								work_d.hours       = 8'd0;
								work_d.day_of_year = work_d.day_of_year + 9'd1;
							end
							if (work_d.day_of_year == 9'd367) begin
								work_d.day_of_year = 9'd0;
								work_d.year        = work_d.year + 8'd1;
							end
							pub_d         = work_d;
							time_update_d = 1'b1;
						end
						default: ;
					endcase
				end else begin
					if (evt.sym == SYM_ONE) begin
						if (marker_index_q == 4'd4) begin
							// day hundreds in bits 0 and 1, tenths in bits 5 to 8
							if (group_bit_index_q == 5'd0) begin
								group_sum_d = group_sum_q + 9'd100;
							end else if (group_bit_index_q == 5'd1) begin
								group_sum_d = group_sum_q + 9'd200;
							end else begin
								work_d.tenths = work_q.tenths + bump;
							end
						end else begin
							group_sum_d = group_sum_q + bcd_weight(group_bit_index_q);
						end
					end
					if (group_bit_index_q != 5'd31) begin
						group_bit_index_d = group_bit_index_q + 5'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_symbol_q     <= SYM_NONE;
			in_frame_q        <= 1'b0;
			marker_index_q    <= 4'd0;
			group_bit_index_q <= 5'd0;
			group_sum_q       <= 9'd0;
			work_q            <= '0;
			pub_q             <= '0;
			frame_start_q     <= 1'b0;
			time_update_q     <= 1'b0;
		end else if (adv) begin
			last_symbol_q     <= last_symbol_d;
			in_frame_q        <= in_frame_d;
			marker_index_q    <= marker_index_d;
			group_bit_index_q <= group_bit_index_d;
			group_sum_q       <= group_sum_d;
			work_q            <= work_d;
			pub_q             <= pub_d;
			frame_start_q     <= frame_start_d;
			time_update_q     <= time_update_d;
		end
	end

	assign frame_start = frame_start_q;
	assign time_update = time_update_q;
	assign pub         = pub_q;

	a_mi_range: assert property (@(posedge clk) disable iff (!arst_n)
		marker_index_q <= MARK_LAST)
		else $error("marker index out of range");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(frame_start_q && time_update_q))
		else $error("frame start and time update on one beat");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		frame_start_q |-> (in_frame_q && marker_index_q == 4'd0 && group_sum_q == 9'd0))
		else $error("frame start left stale frame state");

	a_update_at_publish: assert property (@(posedge clk) disable iff (!arst_n)
		time_update_q |-> (in_frame_q && marker_index_q == MARK_PUBLISH && pub_q == work_q))
		else $error("time update outside the publish marker");

endmodule

`default_nettype wire

@@ design/irig_b_time_code_decoder_core.sv @@
// IRIG-B time code decoder, top level: input stage, threshold registers,
// output handshake. Depends on irigb_pkg, irigb_pulse and irigb_frame.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one line sample per beat, level in bit 0.
//   Every accepted sample yields exactly one result beat on m_tvalid/m_tready:
//   m_tuser holds frame_start (bit 0) and time_update (bit 1), m_tdata the
//   published time. The result beat is offered once its sample has passed
//   the input register and the result register; one sample per cycle is
//   taken sustained while m_tready stays high.
//   An input register holds the sample; the decoder state and the result
//   registers are updated together when that sample moves into the result
//   slot, so the published time on m_tdata holds steady while a result waits.
//   When the receiver stalls, a waiting result holds, one more sample parks in
//   the input register, and s_tready drops until the result is taken.
//   Thresholds are written through cfg_we/cfg_index/cfg_data while idle
//   (user's duty, unenforced). Reset clears the decoder and published time
//   and restores default thresholds (zero 1..3 ticks, marker 7..9 ticks).
`timescale 1ns / 1ps
`default_nettype none

module irig_b_time_code_decoder_core
	import irigb_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // seconds[7:0] minutes[15:8] hours[23:16]
	                                    // day_of_year[32:24] tenths[36:33]
	                                    // year[44:37], [47:45] zero
	output logic [1:0]       m_tuser,   // [0] frame_start, [1] time_update
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic     valid_s1;
	logic     level_s1;
	logic     m_valid_q;
	logic     adv;
	thr_t     thr_q;
	sym_evt_t evt;
	time_t    pub;
	logic     frame_start;
	logic     time_update;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			level_s1 <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.zero_min <= THR_W'(1);
			thr_q.zero_max <= THR_W'(3);
			thr_q.mark_min <= THR_W'(7);
			thr_q.mark_max <= THR_W'(9);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_MIN: thr_q.zero_min <= cfg_data;
				REG_ZERO_MAX: thr_q.zero_max <= cfg_data;
				REG_MARK_MIN: thr_q.mark_min <= cfg_data;
				REG_MARK_MAX: thr_q.mark_max <= cfg_data;
			endcase
		end
	end

	irigb_pulse #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_pulse (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.level (level_s1),
		.thr   (thr_q),
		.evt   (evt)
	);

	irigb_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.evt        (evt),
		.frame_start(frame_start),
		.time_update(time_update),
		.pub        (pub)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, pub};
	assign m_tuser  = {time_update, frame_start};

endmodule

`default_nettype wire
